>>> hw/rtl/pidpr_pkg.sv
// shared types and constants of the pid power regulator
package pidpr_pkg;

  localparam int unsigned GainW  = 32;
  localparam int unsigned ErrW   = 32;
  localparam int unsigned DriveW = 48;
  localparam int unsigned TermW  = 40;  // q24.16 part of a gain times error product
  localparam int unsigned DTermW = 41;  // q25.16 part of a gain times error difference
  localparam int unsigned SumW   = 49;  // integral plus both terms, before saturation
  localparam int unsigned CfgIdxW = 3;

  // op codes carried in tuser
  localparam logic OP_PROCESS = 1'b0;
  localparam logic OP_CLEAR   = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_GAIN_P       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_GAIN_I       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_GAIN_D       = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_MAX = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INTEGRAL_MIN = 3'd4;

  // register reset values
  localparam logic [GainW-1:0]  GAIN_P_RST       = 32'd1677722;
  localparam logic [GainW-1:0]  GAIN_I_RST       = 32'd16777;
  localparam logic [GainW-1:0]  GAIN_D_RST       = 32'd0;
  localparam logic [DriveW-1:0] INTEGRAL_MAX_RST = 48'h0000_FFFF_0000;
  localparam logic [DriveW-1:0] INTEGRAL_MIN_RST = 48'hFFFF_0001_0000;

  localparam logic [DriveW-1:0] DRIVE_MAX = {1'b0, {(DriveW-1){1'b1}}};
  localparam logic [DriveW-1:0] DRIVE_MIN = {1'b1, {(DriveW-1){1'b0}}};

  // product stage payload
  typedef struct packed {
    logic                     op;
    logic                     int_upd;   // gain_i nonzero: integral accumulates
    logic                     d_en;      // derivative term included
    logic signed [TermW-1:0]  p_term;
    logic signed [TermW-1:0]  i_term;
    logic signed [DTermW-1:0] d_term;
  } prod_t;

endpackage

>>> hw/rtl/pid_power_regulator.sv
// throughput: one word per cycle; stalls only when the output word is held
// the pipeline is input register, product register, result register
// a clear word takes the same path and produces no output word
// reset returns gains and clamps to defaults and zeroes integral, last error, started
module pid_power_regulator
  import pidpr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [ErrW-1:0]      s_axis_tdata,   // [31:0] error_in
  input  logic                 s_axis_tuser,   // [0] op
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [DriveW-1:0]    m_axis_tdata,   // [47:0] drive
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [DriveW-1:0]    cfg_data_i
);

  logic              advance;

  logic [GainW-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [DriveW-1:0] int_max_q, int_min_q;

  logic              in_valid_q, in_op_q;
  logic [ErrW-1:0]   in_err_q;

  logic [ErrW-1:0]   last_error_q;
  logic              started_q;

  logic              p_valid_q;
  prod_t             prod_q, prod_d;

  logic [DriveW-1:0] integral_q, integral_d;
  logic              out_valid_q;
  logic [DriveW-1:0] drive_q, drive_d;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = advance;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = drive_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q  <= GAIN_P_RST;
      gain_i_q  <= GAIN_I_RST;
      gain_d_q  <= GAIN_D_RST;
      int_max_q <= INTEGRAL_MAX_RST;
      int_min_q <= INTEGRAL_MIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN_P:       gain_p_q  <= cfg_data_i[GainW-1:0];
        REG_GAIN_I:       gain_i_q  <= cfg_data_i[GainW-1:0];
        REG_GAIN_D:       gain_d_q  <= cfg_data_i[GainW-1:0];
        REG_INTEGRAL_MAX: int_max_q <= cfg_data_i;
        REG_INTEGRAL_MIN: int_min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (advance) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && s_axis_tvalid) begin
      in_op_q  <= s_axis_tuser;
      in_err_q <= s_axis_tdata;
    end
  end

  // product stage
  logic signed [2*GainW-1:0]  p_prod, i_prod;
  logic signed [ErrW:0]       err_diff;
  logic signed [2*GainW:0]    d_prod;

  always_comb begin
    p_prod   = $signed(gain_p_q) * $signed(in_err_q);
    i_prod   = $signed(gain_i_q) * $signed(in_err_q);
    err_diff = $signed({in_err_q[ErrW-1], in_err_q})
             - $signed({last_error_q[ErrW-1], last_error_q});
    d_prod   = $signed(gain_d_q) * err_diff;

    prod_d.op      = in_op_q;
    prod_d.int_upd = (gain_i_q != '0);
    prod_d.d_en    = started_q;
    prod_d.p_term  = p_prod[2*GainW-1:24];
    prod_d.i_term  = i_prod[2*GainW-1:24];
    prod_d.d_term  = d_prod[2*GainW:24];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q    <= 1'b0;
      started_q    <= 1'b0;
      last_error_q <= '0;
    end else if (advance) begin
      p_valid_q <= in_valid_q;
      if (in_valid_q) begin
        if (in_op_q == OP_CLEAR) begin
          started_q    <= 1'b0;
          last_error_q <= '0;
        end else begin
          started_q    <= 1'b1;
          last_error_q <= in_err_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      prod_q <= prod_d;
    end
  end

  // integral update, sum and saturation
  logic signed [SumW-1:0] acc, lim, max_x, min_x, sum;

  always_comb begin
    acc   = $signed({integral_q[DriveW-1], integral_q})
          + SumW'(prod_q.i_term);
    max_x = $signed({int_max_q[DriveW-1], int_max_q});
    min_x = $signed({int_min_q[DriveW-1], int_min_q});

    // upper limit first, then the lower one, so min wins when the limits cross
    lim = (acc > max_x) ? max_x : acc;
    if (lim < min_x) begin
      lim = min_x;
    end

    integral_d = integral_q;
    if (prod_q.int_upd) begin
      integral_d = lim[DriveW-1:0];
    end

    sum = $signed({integral_d[DriveW-1], integral_d}) + SumW'(prod_q.p_term)
        + (prod_q.d_en ? SumW'(prod_q.d_term) : SumW'(0));

    if (sum[SumW-1] != sum[SumW-2]) begin
      drive_d = sum[SumW-1] ? DRIVE_MIN : DRIVE_MAX;
    end else begin
      drive_d = sum[DriveW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      integral_q  <= '0;
    end else if (advance) begin
      out_valid_q <= p_valid_q && (prod_q.op == OP_PROCESS);
      if (p_valid_q) begin
        integral_q <= (prod_q.op == OP_CLEAR) ? '0 : integral_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && p_valid_q) begin
      drive_q <= drive_d;
    end
  end

  // a clear word never reaches the output
  a_clear_no_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && p_valid_q && prod_q.op == OP_CLEAR) |=> !m_axis_tvalid)
    else $error("clear word produced an output word");

  // a clear word leaving the input stage resets the derivative history
  a_clear_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && in_op_q == OP_CLEAR) |=> (!started_q && last_error_q == '0))
    else $error("derivative history not cleared");

  // a sample leaving the input stage is kept as last error
  a_sample_history: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && in_valid_q && in_op_q == OP_PROCESS)
      |=> (started_q && last_error_q == $past(in_err_q)))
    else $error("last error not tracked");

  // an accumulating update keeps the integral inside the clamp, or at the lower limit when the limits cross
  a_integral_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && p_valid_q && prod_q.op == OP_PROCESS && prod_q.int_upd)
      |=> (($signed(integral_q) <= $signed($past(int_max_q))
            && $signed(integral_q) >= $signed($past(int_min_q)))
           || integral_q == $past(int_min_q)))
    else $error("integral outside clamp");

endmodule

>>> sim/pidpr_checker.sv
`timescale 1ns / 100ps
// checker for the pid power regulator: predicts drive words and compares them
module pidpr_checker
  import pidpr_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  input  logic               s_tready_i,
  input  logic [ErrW-1:0]    s_tdata_i,    // [31:0] error_in
  input  logic               s_tuser_i,    // [0] op
  input  logic               m_tvalid_i,
  input  logic               m_tready_i,
  input  logic [DriveW-1:0]  m_tdata_i,    // [47:0] drive
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DriveW-1:0]  cfg_data_i,
  output int                 fail_cnt_o,
  output int                 pending_o
);

  localparam int unsigned WideW      = 80;
  localparam int unsigned FracShift  = 24;
  localparam int unsigned ShownFails = 40;

  logic signed [GainW-1:0]  kp, ki, kd;
  logic signed [DriveW-1:0] integ_hi, integ_lo;
  logic signed [ErrW-1:0]   prev_err;
  logic signed [DriveW-1:0] integ;
  logic                     primed;
  logic [DriveW-1:0]        drive_q[$];
  logic [DriveW-1:0]        want;
  int                       fails = 0;
  int                       depth = 0;

  assign fail_cnt_o = fails;
  assign pending_o  = depth;

  task automatic report(input string what, input logic [DriveW-1:0] got,
                        input logic [DriveW-1:0] exp_v);
    if (fails < ShownFails) begin
      $display("[%0t] %s: got %h, want %h", $time, what, got, exp_v);
    end
    fails++;
  endtask

  // one control sample: updates integral and last error, returns the drive word
  function automatic logic [DriveW-1:0] regulate(input logic signed [ErrW-1:0] err);
    logic signed [WideW-1:0] e_w, prev_w, p_w, i_w, d_w, acc, total, top, bottom;
    e_w    = err;
    prev_w = prev_err;
    p_w    = kp;
    i_w    = ki;
    d_w    = kd;
    total  = (p_w * e_w) >>> FracShift;
    if (ki != 0) begin
      acc    = integ;
      acc    = acc + ((i_w * e_w) >>> FracShift);
      top    = integ_hi;
      bottom = integ_lo;
      // upper clamp first, so a crossed lower limit wins
      if (acc > top) acc = top;
      if (acc < bottom) acc = bottom;
      integ = acc[DriveW-1:0];
    end
    total = total + integ;
    if (primed) begin
      total = total + ((d_w * (e_w - prev_w)) >>> FracShift);
    end
    primed   = 1'b1;
    prev_err = err;
    top      = $signed(DRIVE_MAX);
    bottom   = $signed(DRIVE_MIN);
    if (total > top) begin
      total = top;
    end else if (total < bottom) begin
      total = bottom;
    end
    return total[DriveW-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp       = GAIN_P_RST;
      ki       = GAIN_I_RST;
      kd       = GAIN_D_RST;
      integ_hi = INTEGRAL_MAX_RST;
      integ_lo = INTEGRAL_MIN_RST;
      prev_err = '0;
      integ    = '0;
      primed   = 1'b0;
      drive_q.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (drive_q.size() == 0) begin
          report("drive word with nothing expected", m_tdata_i, '0);
        end else begin
          want = drive_q.pop_front();
          if (m_tdata_i !== want) report("drive mismatch", m_tdata_i, want);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        if (s_tuser_i == OP_CLEAR) begin
          prev_err = '0;
          integ    = '0;
          primed   = 1'b0;
        end else begin
          drive_q.push_back(regulate(s_tdata_i));
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN_P:       kp = cfg_data_i[GainW-1:0];
          REG_GAIN_I:       ki = cfg_data_i[GainW-1:0];
          REG_GAIN_D:       kd = cfg_data_i[GainW-1:0];
          REG_INTEGRAL_MAX: integ_hi = cfg_data_i;
          REG_INTEGRAL_MIN: integ_lo = cfg_data_i;
          default: ;
        endcase
      end
    end
    depth <= drive_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps
// testbench top for the pid power regulator: stimulus, idling phases, verdict
module tb;
  import pidpr_pkg::*;

  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned ChunkWords  = 60;
  localparam int unsigned DrainCycles = 8;     // longer than a word takes through the pipeline
  localparam int unsigned DrainLimit  = 4000;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               s_valid = 1'b0;
  logic               s_ready;
  logic [ErrW-1:0]    s_data = '0;
  logic               s_user = OP_PROCESS;
  logic               m_valid;
  logic               m_ready = 1'b0;
  logic [DriveW-1:0]  m_data;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = REG_GAIN_P;
  logic [DriveW-1:0]  cfg_data = '0;
  int                 fails;
  int                 pending;
  int unsigned        gap_pct = 0;
  int unsigned        stall_pct = 0;
  int                 hold_reqs = 0;
  int                 hold_seen = 0;
  int unsigned        hold_left = 0;

  pid_power_regulator dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  pidpr_checker checker_i (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .s_tvalid_i (s_valid),
    .s_tready_i (s_ready),
    .s_tdata_i  (s_data),
    .s_tuser_i  (s_user),
    .m_tvalid_i (m_valid),
    .m_tready_i (m_ready),
    .m_tdata_i  (m_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .fail_cnt_o (fails),
    .pending_o  (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_left <= HoldCycles;
      m_ready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_ready   <= 1'b0;
    end else begin
      m_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [ErrW-1:0] pick_error();
    case ($urandom_range(4))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(4))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return 32'h0000_0000;
          3: return 32'hffff_ffff;
          default: return 32'h0000_0001;
        endcase
      end
      default: return $signed($urandom) >>> $urandom_range(8, 24);
    endcase
  endfunction

  function automatic logic [GainW-1:0] pick_gain();
    case ($urandom_range(4))
      0: return $urandom;
      1: begin
        case ($urandom_range(2))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          default: return 32'h0000_0000;
        endcase
      end
      2, 3: return $signed($urandom) >>> $urandom_range(6, 20);
      default: return $signed($urandom) >>> 24;
    endcase
  endfunction

  function automatic logic [DriveW-1:0] pick_limit(input bit upper);
    logic [63:0]       r;
    logic [DriveW-1:0] m;
    r = {$urandom, $urandom};
    case ($urandom_range(5))
      0: return r[DriveW-1:0];
      1: return upper ? DRIVE_MAX : DRIVE_MIN;
      2: return upper ? DRIVE_MIN : DRIVE_MAX;   // crossed limits
      default: begin
        m = r[DriveW-1:0] >> $urandom_range(8, 30);
        return upper ? m : -m;
      end
    endcase
  endfunction

  task automatic send_word(input logic op, input logic [ErrW-1:0] err);
    while ($urandom_range(99) < gap_pct) begin
      s_valid <= 1'b0;
      @(posedge clk);
    end
    s_valid <= 1'b1;
    s_user  <= op;
    s_data  <= err;
    @(posedge clk);
    while (!s_ready) @(posedge clk);
  endtask

  // no word in flight, and a clear word has had time to pass through
  task automatic wait_idle();
    s_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DriveW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // gains carry junk in the unused upper bits; an unused index gets junk too
  task automatic load_regs(input logic [GainW-1:0] gp, gi, gd,
                           input logic [DriveW-1:0] hi, lo);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_GAIN_P, {junk[15:0], gp});
    write_reg(REG_GAIN_I, {junk[31:16], gi});
    write_reg(REG_GAIN_D, {junk[47:32], gd});
    write_reg(REG_INTEGRAL_MAX, hi);
    write_reg(REG_INTEGRAL_MIN, lo);
    write_reg(CfgIdxW'($urandom_range(REG_INTEGRAL_MIN + 1, (1 << CfgIdxW) - 1)),
              junk[DriveW-1:0]);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned waited;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset gains: first sample, error extremes, clear, first sample again
    send_word(OP_PROCESS, 32'd100);
    send_word(OP_PROCESS, -32'sd100);
    send_word(OP_PROCESS, 32'h7fff_ffff);
    send_word(OP_PROCESS, 32'h8000_0000);
    send_word(OP_CLEAR, 32'hffff_ffff);
    send_word(OP_PROCESS, 32'h0001_2345);

    // crossed clamps pin the integral at the top, so the sum saturates high when the terms push up
    wait_idle();
    load_regs(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, DRIVE_MIN, DRIVE_MAX);
    send_word(OP_PROCESS, 32'h7fff_ffff);
    send_word(OP_PROCESS, 32'h8000_0000);
    send_word(OP_PROCESS, 32'h7fff_ffff);
    send_word(OP_CLEAR, 32'h0000_0000);
    send_word(OP_PROCESS, 32'h0000_0000);

    // integral pinned at the bottom, sum saturates low
    wait_idle();
    load_regs(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, DRIVE_MIN, DRIVE_MIN);
    send_word(OP_PROCESS, 32'h8000_0000);
    send_word(OP_PROCESS, 32'h7fff_ffff);

    // integral pinned at a negative upper limit, then frozen with limits it would violate
    wait_idle();
    load_regs(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, -48'sd1099511627776, DRIVE_MIN);
    send_word(OP_CLEAR, 32'h0000_0000);
    send_word(OP_PROCESS, 32'h8000_0000);
    send_word(OP_PROCESS, 32'h7fff_ffff);
    send_word(OP_PROCESS, 32'h8000_0000);
    wait_idle();
    load_regs(32'h0100_0000, 32'h0000_0000, 32'h0100_0000, 48'd0, 48'd0);
    send_word(OP_PROCESS, 32'h7fff_ffff);
    send_word(OP_PROCESS, 32'h8000_0000);
    send_word(OP_PROCESS, 32'h0000_0001);

    for (int ph = 0; ph < 4; ph++) begin
      for (int ch = 0; ch < 4; ch++) begin
        wait_idle();
        case (ph)
          0: begin gap_pct = 0;  stall_pct <= 0;  end
          1: begin gap_pct = 49; stall_pct <= 0;  end
          2: begin gap_pct = 0;  stall_pct <= 49; end
          default: begin gap_pct = 30; stall_pct <= 30; end
        endcase
        load_regs(pick_gain(), pick_gain(), pick_gain(), pick_limit(1'b1), pick_limit(1'b0));
        // long receiver hold-off while words keep coming
        if (ph == 0 && ch == 1) hold_reqs <= hold_reqs + 1;
        for (int n = 0; n < ChunkWords; n++) begin
          send_word(($urandom_range(24) == 0) ? OP_CLEAR : OP_PROCESS, pick_error());
        end
      end
    end

    s_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DrainLimit) begin
      @(posedge clk);
      waited++;
    end
    repeat (DrainCycles) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/pidpr_pkg.sv
hw/rtl/pid_power_regulator.sv
sim/pidpr_checker.sv
sim/tb.sv
